// ===== src/dqvd_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual quadrature velocity decoder package
// Shared widths, request and result types and constants for the decoder.
// ----------------------------------------------------------------------------
package dqvd_pkg;

    // Width of the running per-wheel counts (8 to 32).
    localparam int COUNT_BITS = 16;

    localparam int GAIN_BITS  = 32;
    localparam int FIELD_CNT_BITS = 16;
    localparam int VEL_BITS   = 48;

    // Product of a signed count with the unsigned gain, widened to at least
    // the velocity width so that narrow counts sign-extend into it.
    localparam int PROD_BITS  = COUNT_BITS + GAIN_BITS + 1;
    localparam int PROD_EXT   = (PROD_BITS > VEL_BITS) ? PROD_BITS : VEL_BITS;
    localparam int CNT_EXT    = (COUNT_BITS > FIELD_CNT_BITS) ? COUNT_BITS : FIELD_CNT_BITS;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 32'h0100_0000;

    typedef logic signed [COUNT_BITS-1:0] t_count;

    localparam t_count CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam t_count CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_TICK   = 1'b1
    } t_func;

    typedef struct packed {
        logic func;
        logic right_a;
        logic right_b;
        logic left_a;
        logic left_b;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_CNT_BITS-1:0] right_count;
        logic signed [FIELD_CNT_BITS-1:0] left_count;
        logic signed [VEL_BITS-1:0]       right_vel;
        logic signed [VEL_BITS-1:0]       left_vel;
        logic signed [VEL_BITS-1:0]       mean_vel;
        logic                             right_skip;
        logic                             left_skip;
    } t_out;

    // What one wheel lane hands to the merge stage at a tick.
    typedef struct packed {
        t_count count;
        logic   skip;
    } t_lane_snap;

endpackage

// ===== src/dqvd_lane.sv =====
// ----------------------------------------------------------------------------
// Dual quadrature velocity decoder lane
// One wheel's x4 decoder: edge detection, saturating count and skip flag.
// ----------------------------------------------------------------------------
module dqvd_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sample,
    input  logic                 i_tick,
    input  logic                 i_a,
    input  logic                 i_b,
    output dqvd_pkg::t_lane_snap o_snap
);

    logic            r_prev_a;
    logic            r_prev_b;
    logic            r_primed;
    dqvd_pkg::t_count r_acc;
    dqvd_pkg::t_count n_acc;
    logic            r_skip;
    logic            n_skip;

    logic w_da;
    logic w_db;
    logic w_same;

    assign w_da   = i_a ^ r_prev_a;
    assign w_db   = i_b ^ r_prev_b;
    assign w_same = (i_a == i_b);

    always_comb begin
        n_acc  = r_acc;
        n_skip = r_skip;
        if (i_tick) begin
            n_acc  = '0;
            n_skip = 1'b0;
        end else if (i_sample && r_primed) begin
            if (w_da && w_db) begin
                n_skip = 1'b1;
            end else if (w_da || w_db) begin
                // A alone steps down when A equals B; B alone steps up then.
                if (w_da ^ w_same) begin
                    if (r_acc != dqvd_pkg::CNT_MAX) begin
                        n_acc = r_acc + dqvd_pkg::t_count'(1);
                    end
                end else begin
                    if (r_acc != dqvd_pkg::CNT_MIN) begin
                        n_acc = r_acc - dqvd_pkg::t_count'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= 1'b0;
            r_prev_b <= 1'b0;
            r_primed <= 1'b0;
            r_acc    <= '0;
            r_skip   <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_skip <= n_skip;
            if (i_sample) begin
                r_prev_a <= i_a;
                r_prev_b <= i_b;
                r_primed <= 1'b1;
            end
        end
    end

    assign o_snap.count = r_acc;
    assign o_snap.skip  = r_skip;

endmodule

// ===== src/dqvd_merge.sv =====
// ----------------------------------------------------------------------------
// Dual quadrature velocity decoder merge
// Three-stage pipeline: snapshot, gain multiply per wheel, mean and output.
// ----------------------------------------------------------------------------
module dqvd_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  dqvd_pkg::t_lane_snap                i_right,
    input  dqvd_pkg::t_lane_snap                i_left,
    input  logic [dqvd_pkg::GAIN_BITS-1:0]      i_gain,
    output logic                                o_ready,
    output logic                                o_valid,
    output dqvd_pkg::t_out                      o_data,
    input  logic                                i_stall
);

    // Snapshot stage.
    logic                 r_v1;
    dqvd_pkg::t_lane_snap r_s1_r;
    dqvd_pkg::t_lane_snap r_s1_l;

    // Product stage.
    logic                                 r_v2;
    dqvd_pkg::t_lane_snap                 r_s2_r;
    dqvd_pkg::t_lane_snap                 r_s2_l;
    logic signed [dqvd_pkg::VEL_BITS-1:0] r_vel_r;
    logic signed [dqvd_pkg::VEL_BITS-1:0] r_vel_l;

    // Output stage.
    logic           r_v3;
    dqvd_pkg::t_out r_out;

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;

    logic signed [dqvd_pkg::PROD_EXT-1:0]   w_prod_r;
    logic signed [dqvd_pkg::PROD_EXT-1:0]   w_prod_l;
    logic signed [dqvd_pkg::PROD_EXT-1:0]   w_cnt1_r;
    logic signed [dqvd_pkg::PROD_EXT-1:0]   w_cnt1_l;
    logic signed [dqvd_pkg::PROD_EXT-1:0]   w_gain_ext;
    logic signed [dqvd_pkg::VEL_BITS:0]     w_sum;
    logic signed [dqvd_pkg::CNT_EXT-1:0]    w_cnt_r;
    logic signed [dqvd_pkg::CNT_EXT-1:0]    w_cnt_l;
    logic signed [dqvd_pkg::GAIN_BITS:0]    w_gain_s;

    assign w_rdy3 = !r_v3 || !i_stall;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_gain_s = $signed({1'b0, i_gain});

    // Both factors are sign-extended to the full product width.
    assign w_cnt1_r   = $signed({{(dqvd_pkg::PROD_EXT-dqvd_pkg::COUNT_BITS)
                                  {r_s1_r.count[dqvd_pkg::COUNT_BITS-1]}}, r_s1_r.count});
    assign w_cnt1_l   = $signed({{(dqvd_pkg::PROD_EXT-dqvd_pkg::COUNT_BITS)
                                  {r_s1_l.count[dqvd_pkg::COUNT_BITS-1]}}, r_s1_l.count});
    assign w_gain_ext = $signed({{(dqvd_pkg::PROD_EXT-dqvd_pkg::GAIN_BITS-1){1'b0}},
                                 w_gain_s});
    assign w_prod_r = w_cnt1_r * w_gain_ext;
    assign w_prod_l = w_cnt1_l * w_gain_ext;

    assign w_sum   = {r_vel_r[dqvd_pkg::VEL_BITS-1], r_vel_r}
                   + {r_vel_l[dqvd_pkg::VEL_BITS-1], r_vel_l};
    assign w_cnt_r = r_s2_r.count;
    assign w_cnt_l = r_s2_l.count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_load;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_load) begin
            r_s1_r <= i_right;
            r_s1_l <= i_left;
        end
        if (w_rdy2 && r_v1) begin
            r_s2_r  <= r_s1_r;
            r_s2_l  <= r_s1_l;
            r_vel_r <= w_prod_r[dqvd_pkg::VEL_BITS-1:0];
            r_vel_l <= w_prod_l[dqvd_pkg::VEL_BITS-1:0];
        end
        if (w_rdy3 && r_v2) begin
            r_out.right_count <= w_cnt_r[dqvd_pkg::FIELD_CNT_BITS-1:0];
            r_out.left_count  <= w_cnt_l[dqvd_pkg::FIELD_CNT_BITS-1:0];
            r_out.right_vel   <= r_vel_r;
            r_out.left_vel    <= r_vel_l;
            // Arithmetic halving of the 49-bit sum rounds toward minus infinity.
            r_out.mean_vel    <= w_sum[dqvd_pkg::VEL_BITS:1];
            r_out.right_skip  <= r_s2_r.skip;
            r_out.left_skip   <= r_s2_l.skip;
        end
    end

    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_out;

endmodule

// ===== src/dual_quadrature_velocity_decoder.sv =====
// ----------------------------------------------------------------------------
// Dual quadrature velocity decoder
// Two-wheel x4 quadrature decoder with a periodic velocity latch.
// ----------------------------------------------------------------------------
// Each request is either a pin sample carrying the A and B levels of both
// encoders or a period tick. Pin samples are taken one per clock, always,
// whenever o_stall is low, and produce no result; each wheel lane compares the
// new levels with the stored ones and moves its saturating signed count by
// one step, or sets its sticky skip flag when both channels changed at once.
// The first sample after reset only captures the levels. A tick snapshots
// both counts and skip flags, clears them in the same cycle, and sends the
// snapshot down a three-stage merge pipeline (snapshot, one count-by-gain
// multiply per wheel, then the halved mean) whose last stage is the output
// register. o_valid rises once the tick has passed the snapshot, product and
// output registers, and a new request can be accepted every cycle in which
// o_stall is low; o_stall rises only when all three pipeline stages
// are full and the output is stalled. The gain register is unsigned Q8.24,
// resets to 1.0, and should be written only while no tick is in flight.
module dual_quadrature_velocity_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  dqvd_pkg::t_in                   i_data,
    output logic                            o_stall,
    output logic                            o_valid,
    output dqvd_pkg::t_out                  o_data,
    input  logic                            i_stall,
    input  logic                            i_cfg_we,
    input  logic [dqvd_pkg::GAIN_BITS-1:0]  i_cfg_wdata
);

    logic [dqvd_pkg::GAIN_BITS-1:0] r_gain;

    logic w_ready;
    logic w_accept;
    logic w_sample;
    logic w_tick;

    dqvd_pkg::t_lane_snap w_snap_r;
    dqvd_pkg::t_lane_snap w_snap_l;

    // The pipeline ready never depends on the request payload.
    assign o_stall  = !w_ready;
    assign w_accept = i_valid && w_ready;
    assign w_tick   = w_accept && (i_data.func == dqvd_pkg::FUNC_TICK);
    assign w_sample = w_accept && (i_data.func == dqvd_pkg::FUNC_SAMPLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= dqvd_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    // The two wheel lanes run side by side on the same request.
    dqvd_lane u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (w_sample),
        .i_tick   (w_tick),
        .i_a      (i_data.right_a),
        .i_b      (i_data.right_b),
        .o_snap   (w_snap_r)
    );

    dqvd_lane u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (w_sample),
        .i_tick   (w_tick),
        .i_a      (i_data.left_a),
        .i_b      (i_data.left_b),
        .o_snap   (w_snap_l)
    );

    // The merge pipeline scales both snapshots and forms the mean.
    dqvd_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_tick),
        .i_right  (w_snap_r),
        .i_left   (w_snap_l),
        .i_gain   (r_gain),
        .o_ready  (w_ready),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .i_stall  (i_stall)
    );

endmodule

// ===== src/dqvd_checker.sv =====
// ----------------------------------------------------------------------------
// Dual quadrature velocity decoder checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module dqvd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input dqvd_pkg::t_out o_data,
    input logic           i_stall
);

    // A result held under stall stays valid.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A result held under stall keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("result changed while stalled");

    // The mean is the floor-halved sum of the two velocities.
    a_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.mean_vel == 48'((
            {o_data.right_vel[47], o_data.right_vel}
          + {o_data.left_vel[47], o_data.left_vel}) >> 1))
        else $error("mean velocity does not match the wheel velocities");

    // A zero right count always scales to a zero right velocity.
    a_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.right_count == 16'sd0) |-> o_data.right_vel == 48'sd0)
        else $error("zero count gave a nonzero velocity");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind dual_quadrature_velocity_decoder dqvd_checker u_dqvd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);

// ===== test/tb_dual_quadrature_velocity_decoder.sv =====
// ----------------------------------------------------------------------------
// Dual quadrature velocity decoder testbench
// Drives pin-sample and period-tick requests into the decoder with random
// idling and backpressure on both channels. An in-bench copy of the decoder
// state predicts each period report, and every report that leaves the block
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_dual_quadrature_velocity_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    // Spare cycles allowed after the last report before the block is considered idle.
    localparam int SETTLE_CYCLES = 8;
    // Upper bound on a wait for outstanding reports before giving up.
    localparam int DRAIN_LIMIT   = 5000;
    // Length of the long receiver hold-off used to fill the pipeline.
    localparam int HOLD_CYCLES   = 150;
    // Length of the long one-direction runs at the largest gain.
    localparam int RUN_STEPS     = 100;
    localparam int RANDOM_ITEMS  = 1200;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    dqvd_pkg::t_in                  i_data;
    logic                           o_stall;
    logic                           o_valid;
    dqvd_pkg::t_out                 o_data;
    logic                           i_stall;
    logic                           i_cfg_we;
    logic [dqvd_pkg::GAIN_BITS-1:0] i_cfg_wdata;

    dual_quadrature_velocity_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted decoder state. It is updated at the clock edge where a
    // request is accepted, so it always mirrors what the block has seen.
    // ------------------------------------------------------------------------
    logic [dqvd_pkg::GAIN_BITS-1:0] gain_q8_24;
    logic [3:0]                     last_pins;   // {left_b, left_a, right_b, right_a}
    logic                           pins_seen;
    dqvd_pkg::t_count               right_cnt;
    dqvd_pkg::t_count               left_cnt;
    logic [1:0]                     skip_seen;   // bit 0 right, bit 1 left

    // Period reports predicted but not yet seen at the output.
    dqvd_pkg::t_out report_q[$];

    int   fail_count     = 0;
    int   accepted_count = 0;

    // Shared knobs: idling on or off for both sides, and the long hold-off.
    logic idle_on  = 1'b1;
    logic hold_req = 1'b0;
    logic rx_hold  = 1'b0;

    // Stimulus-side phase of each encoder along its quadrature cycle.
    int   r_phase = 0;
    int   l_phase = 0;

    // Moves a saturating count one step for a single encoder. A and B are the
    // new levels; da and db tell which channel changed. A double change is a
    // skip and leaves the count alone.
    function automatic dqvd_pkg::t_count step_count(dqvd_pkg::t_count cnt, logic a,
                                                    logic b, logic da, logic db);
        logic up;
        if (da == db) begin
            return cnt;
        end
        up = da ? (a != b) : (a == b);
        if (up) begin
            return (cnt == dqvd_pkg::CNT_MAX) ? cnt : dqvd_pkg::t_count'(cnt + 1);
        end
        return (cnt == dqvd_pkg::CNT_MIN) ? cnt : dqvd_pkg::t_count'(cnt - 1);
    endfunction

    // Count times unsigned gain, wrapped to the velocity width.
    function automatic logic signed [dqvd_pkg::VEL_BITS-1:0] scale_count(
            dqvd_pkg::t_count cnt);
        logic signed [63:0] prod;
        prod = 64'(cnt) * $signed({32'd0, gain_q8_24});
        return prod[dqvd_pkg::VEL_BITS-1:0];
    endfunction

    // Applies one accepted request to the predicted state; a tick also
    // produces the report that the block must emit for it.
    task automatic track_request(dqvd_pkg::t_in req);
        dqvd_pkg::t_out                     rpt;
        logic [3:0]                         pins;
        logic [3:0]                         moved;
        logic signed [dqvd_pkg::VEL_BITS:0] vel_sum;
        if (req.func == dqvd_pkg::FUNC_TICK) begin
            rpt.right_count = right_cnt;
            rpt.left_count  = left_cnt;
            rpt.right_vel   = scale_count(right_cnt);
            rpt.left_vel    = scale_count(left_cnt);
            // The mean is the sum shifted right with sign, i.e. floor of half.
            vel_sum         = {rpt.right_vel[dqvd_pkg::VEL_BITS-1], rpt.right_vel} +
                              {rpt.left_vel[dqvd_pkg::VEL_BITS-1], rpt.left_vel};
            rpt.mean_vel    = vel_sum[dqvd_pkg::VEL_BITS:1];
            rpt.right_skip  = skip_seen[0];
            rpt.left_skip   = skip_seen[1];
            report_q.push_back(rpt);
            right_cnt = '0;
            left_cnt  = '0;
            skip_seen = '0;
        end else begin
            pins = {req.left_b, req.left_a, req.right_b, req.right_a};
            // The very first sample after reset only captures the levels.
            if (pins_seen) begin
                moved = pins ^ last_pins;
                if (moved[0] && moved[1]) begin
                    skip_seen[0] = 1'b1;
                end else begin
                    right_cnt = step_count(right_cnt, pins[0], pins[1],
                                           moved[0], moved[1]);
                end
                if (moved[2] && moved[3]) begin
                    skip_seen[1] = 1'b1;
                end else begin
                    left_cnt = step_count(left_cnt, pins[2], pins[3],
                                          moved[2], moved[3]);
                end
            end
            last_pins = pins;
            pins_seen = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side. Each call is entered at a rising edge and returns at the
    // edge where its request was accepted, with valid still high, so a
    // following call with no gap simply replaces the payload.
    // ------------------------------------------------------------------------
    task automatic send_request(dqvd_pkg::t_in req);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        track_request(req);
        accepted_count++;
    endtask

    function automatic logic [1:0] quad_levels(int phase);
        // {A, B} along the forward direction of one encoder.
        case (phase & 3)
            0:       return 2'b00;
            1:       return 2'b10;
            2:       return 2'b11;
            default: return 2'b01;
        endcase
    endfunction

    function automatic int phase_of(logic [1:0] ab);
        case (ab)
            2'b00:   return 0;
            2'b10:   return 1;
            2'b11:   return 2;
            default: return 3;
        endcase
    endfunction

    function automatic dqvd_pkg::t_in pins_req(logic [1:0] right_ab, logic [1:0] left_ab);
        dqvd_pkg::t_in req;
        req.func                   = dqvd_pkg::FUNC_SAMPLE;
        {req.right_a, req.right_b} = right_ab;
        {req.left_a, req.left_b}   = left_ab;
        return req;
    endfunction

    // Moves each encoder by a number of quadrature phases: one is a normal
    // count, two flips both channels at once.
    task automatic move_wheels(int r_step, int l_step);
        r_phase = (r_phase + r_step) & 3;
        l_phase = (l_phase + l_step) & 3;
        send_request(pins_req(quad_levels(r_phase), quad_levels(l_phase)));
    endtask

    // A tick with random pin levels, which the block must ignore.
    task automatic send_tick();
        dqvd_pkg::t_in req;
        req.func = dqvd_pkg::FUNC_TICK;
        {req.right_a, req.right_b, req.left_a, req.left_b} = 4'($urandom_range(0, 15));
        send_request(req);
    endtask

    // Stops offering requests and waits until every predicted report has
    // arrived, then gives the pipeline time to settle.
    task automatic drain_reports();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (report_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The gain is only changed while nothing is in flight.
    task automatic write_gain(logic [dqvd_pkg::GAIN_BITS-1:0] value);
        drain_reports();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        gain_q8_24 = value;
        i_cfg_we   <= 1'b0;
    endtask

    // Step for one encoder in a well-formed period: mostly the period's
    // direction, sometimes a pause or a reversal, rarely a skip.
    function automatic int draw_step(int dir);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            return 2;
        end
        if (pick < 70) begin
            return dir;
        end
        if (pick < 85) begin
            return 0;
        end
        return (dir == 0) ? 1 : -dir;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A tick right after reset reports zeros. The first sample only latches
    // the levels, even though it differs from the reset levels on both
    // channels of both encoders.
    task automatic test_reset_and_first_sample();
        send_tick();
        r_phase = 2;
        l_phase = 2;
        send_request(pins_req(quad_levels(r_phase), quad_levels(l_phase)));
        send_tick();
    endtask

    // Each of the four transitions in each direction on both encoders, plus
    // a sample with no change. The levels survive the ticks in between.
    task automatic test_single_steps();
        repeat (4) move_wheels(1, -1);
        move_wheels(0, 0);
        send_tick();
        repeat (4) move_wheels(-1, 1);
        send_tick();
    endtask

    // A double change sets a sticky skip flag that only a tick clears.
    task automatic test_skip_flags();
        move_wheels(2, 0);
        send_tick();
        move_wheels(1, 2);
        move_wheels(0, 1);
        move_wheels(2, 2);
        send_tick();
        send_tick();
    endtask

    // Positive and negative counts under the gain extremes and a few
    // ordinary values; the odd negative sums check the floor of the mean.
    task automatic test_gain_settings();
        logic [dqvd_pkg::GAIN_BITS-1:0] gains[6];
        int                             steps;
        gains = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'h00FF_FFFF, 32'h0000_0000};
        gains[5] = $urandom();
        foreach (gains[g]) begin
            write_gain(gains[g]);
            steps = $urandom_range(1, 6);
            repeat (steps) move_wheels(1, -1);
            send_tick();
            steps = $urandom_range(1, 3);
            repeat (steps) move_wheels(-1, 0);
            send_tick();
        end
    endtask

    // Long back-to-back runs in one direction build large counts of opposite
    // sign on the two wheels, then the other way round, all at the largest
    // gain.
    task automatic test_long_runs();
        write_gain(32'hFFFF_FFFF);
        idle_on = 1'b0;
        repeat (RUN_STEPS) move_wheels(1, -1);
        send_tick();
        repeat (RUN_STEPS) move_wheels(-1, 1);
        send_tick();
        idle_on = 1'b1;
        write_gain(dqvd_pkg::GAIN_RESET);
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the report pipeline fills and the block stalls its input. The
    // sender then waits until all reports are out.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++) begin
            if (i % 2 == 0) begin
                send_tick();
            end else begin
                move_wheels(draw_step(1), draw_step(-1));
            end
        end
        hold_req = 1'b0;
        drain_reports();
        idle_on = 1'b1;
    endtask

    // Mostly well-formed periods of quadrature motion closed by a tick, with
    // raw pin noise and bursts of back-to-back ticks mixed in. The gain is
    // changed now and then between periods.
    task automatic test_random_traffic(int items);
        int            stop_at;
        int            next_gain_at;
        int            kind;
        int            len;
        int            r_dir;
        int            l_dir;
        dqvd_pkg::t_in req;
        stop_at      = accepted_count + items;
        next_gain_at = accepted_count + 300;
        while (accepted_count < stop_at) begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 99);
            if (kind < 80) begin
                len   = $urandom_range(1, 24);
                r_dir = $urandom_range(0, 2) - 1;
                l_dir = $urandom_range(0, 2) - 1;
                repeat (len) move_wheels(draw_step(r_dir), draw_step(l_dir));
                send_tick();
            end else if (kind < 95) begin
                len = $urandom_range(1, 8);
                repeat (len) begin
                    req = pins_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
                    if ($urandom_range(0, 3) == 0) begin
                        req.func = dqvd_pkg::FUNC_TICK;
                    end else begin
                        r_phase = phase_of({req.right_a, req.right_b});
                        l_phase = phase_of({req.left_a, req.left_b});
                    end
                    send_request(req);
                end
            end else begin
                len = $urandom_range(2, 3);
                repeat (len) send_tick();
            end
            if (accepted_count >= next_gain_at) begin
                case ($urandom_range(0, 3))
                    0:       write_gain(32'hFFFF_FFFF);
                    1:       write_gain(32'h0000_0000);
                    default: write_gain($urandom());
                endcase
                next_gain_at = accepted_count + 300;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Report checker and receiver stall. Each accepted report is compared
    // with the oldest prediction. After each report the receiver draws how
    // many cycles it stalls; the long hold-off is ORed in on top.
    // ------------------------------------------------------------------------
    initial begin : report_checker
        dqvd_pkg::t_out got;
        dqvd_pkg::t_out want;
        int             wait_cycles;
        logic           bad;
        wait_cycles = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = o_data;
                if (report_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected report at %0t: rc=%0d lc=%0d rv=%0d lv=%0d",
                                 $realtime, got.right_count, got.left_count,
                                 got.right_vel, got.left_vel);
                    end
                end else begin
                    want = report_q.pop_front();
                    bad  = (got.right_count !== want.right_count) ||
                           (got.left_count  !== want.left_count)  ||
                           (got.right_vel   !== want.right_vel)   ||
                           (got.left_vel    !== want.left_vel)    ||
                           (got.mean_vel    !== want.mean_vel)    ||
                           (got.right_skip  !== want.right_skip)  ||
                           (got.left_skip   !== want.left_skip);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("report mismatch at %0t", $realtime);
                            $display("  expected rc=%0d lc=%0d rv=%0d lv=%0d mv=%0d rs=%0b ls=%0b",
                                     want.right_count, want.left_count, want.right_vel,
                                     want.left_vel, want.mean_vel, want.right_skip,
                                     want.left_skip);
                            $display("  actual   rc=%0d lc=%0d rv=%0d lv=%0d mv=%0d rs=%0b ls=%0b",
                                     got.right_count, got.left_count, got.right_vel,
                                     got.left_vel, got.mean_vel, got.right_skip,
                                     got.left_skip);
                        end
                    end
                end
                wait_cycles = idle_on ? $urandom_range(0, 12) : 0;
            end else if (wait_cycles > 0) begin
                wait_cycles--;
            end
            i_stall <= (wait_cycles > 0) || rx_hold;
        end
    end

    // Long receiver hold-off, counted here so the request side can keep
    // offering requests meanwhile.
    initial begin : receiver_hold
        forever begin
            wait (hold_req);
            @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
            wait (!hold_req);
        end
    end

    // Hard limit on the whole run.
    initial begin : run_limit
        #20_000_000;
        $display("tb_dual_quadrature_velocity_decoder NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset once, run the tests in turn, then wait for the
    // last reports and give the verdict.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        gain_q8_24  = dqvd_pkg::GAIN_RESET;
        last_pins   = '0;
        pins_seen   = 1'b0;
        right_cnt   = '0;
        left_cnt    = '0;
        skip_seen   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_first_sample();
        test_single_steps();
        test_skip_flags();
        test_gain_settings();
        test_long_runs();
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        drain_reports();
        if (report_q.size() != 0) begin
            fail_count++;
            $display("%0d predicted reports never arrived", report_q.size());
        end
        if (fail_count == 0) begin
            $display("tb_dual_quadrature_velocity_decoder OK");
        end else begin
            $display("tb_dual_quadrature_velocity_decoder NOT OK");
        end
        $finish;
    end

endmodule
